### hw/rtl/mnc_pkg.sv
`timescale 1ns / 1ps
// mnc_pkg: shared types, constants and helpers for the 3x3 mine neighbor counter
// no dependencies

package mnc_pkg;

  localparam int CFG_W     = 11;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 4;
  localparam int WIN_W     = 9;
  localparam int MAX_ROWS  = 1024;

  typedef enum logic [0:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic             cell_mine;
    logic [CNT_W-1:0] neighbor_count;
    logic             frame_last;
  } result_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int unsigned maxv);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (32'(v) > maxv) begin
      res = CFG_W'(maxv);
    end
    return res;
  endfunction

  // mines in the 3x3 window apart from the center cell
  function automatic logic [CNT_W-1:0] ring_count(input logic [WIN_W-1:0] w);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WIN_W; i++) begin
      if (i != 4) begin
        n = n + CNT_W'(w[i]);
      end
    end
    return n;
  endfunction

  function automatic result_t make_result(input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col,
                                          input logic [WIN_W-1:0] w,
                                          input logic             last);
    result_t r;
    r.row_index      = row;
    r.col_index      = col;
    r.cell_mine      = w[4];
    r.neighbor_count = w[4] ? '0 : ring_count(w);
    r.frame_last     = last;
    return r;
  endfunction

endpackage

### hw/rtl/mnc_cell_if.sv
`timescale 1ns / 1ps
// mnc_cell_if, mnc_result_if: valid/ready channels for cell words and result words
// depends on mnc_pkg for field widths

interface mnc_cell_if;
  logic valid;
  logic ready;
  logic req_type;
  logic is_mine;

  modport source (output valid, output req_type, output is_mine, input ready);
  modport sink (input valid, input req_type, input is_mine, output ready);
endinterface

interface mnc_result_if;
  logic                     valid;
  logic                     ready;
  logic [mnc_pkg::IDX_W-1:0] row_index;
  logic [mnc_pkg::IDX_W-1:0] col_index;
  logic                     cell_mine;
  logic [mnc_pkg::CNT_W-1:0] neighbor_count;
  logic                     frame_last;

  modport source (output valid, output row_index, output col_index, output cell_mine,
                  output neighbor_count, output frame_last, input ready);
  modport sink (input valid, input row_index, input col_index, input cell_mine,
                input neighbor_count, input frame_last, output ready);
endinterface

### hw/rtl/mnc_line_store.sv
`timescale 1ns / 1ps
// mnc_line_store: per-column memory of the two rows above, one read and one write port
// registered read with write-to-read bypass on a same-address collision

module mnc_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] q;
  logic [1:0] byp_data;
  logic       byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q        <= mem[rd_addr];
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : q;

endmodule

### hw/rtl/mnc_result_fifo.sv
`timescale 1ns / 1ps
// mnc_result_fifo: small result queue taking up to two words per cycle
// depends on mnc_pkg (result_t) and mnc_result_if

module mnc_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  mnc_pkg::result_t    push0,
  input  mnc_pkg::result_t    push1,
  output logic [3:0]          count,
  mnc_result_if.source        result_out
);
  import mnc_pkg::*;

  localparam int DEPTH = 8;
  localparam int PW    = 3;

  result_t         mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic            pop;
  logic [3:0]      count_next;

  assign pop = result_out.valid && result_out.ready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[PW'(wr_ptr + 1'b1)] <= push1;
    end
  end

  always_comb begin
    count_next = count + 4'(push_n) - 4'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PW'(wr_ptr + PW'(push_n));
      rd_ptr <= PW'(rd_ptr + PW'(pop));
      count  <= count_next;
    end
  end

  assign result_out.valid          = (count != '0);
  assign result_out.row_index      = mem[rd_ptr].row_index;
  assign result_out.col_index      = mem[rd_ptr].col_index;
  assign result_out.cell_mine      = mem[rd_ptr].cell_mine;
  assign result_out.neighbor_count = mem[rd_ptr].neighbor_count;
  assign result_out.frame_last     = mem[rd_ptr].frame_last;

endmodule

### hw/rtl/mine_neighbor_count_3x3.sv
`timescale 1ns / 1ps
// mine_neighbor_count_3x3: streaming 3x3 mine neighbor counter over a raster grid
// depends on mnc_pkg, mnc_cell_if, mnc_line_store, mnc_result_fifo
//
//   port        dir   word
//   cell_in     in    req_type, is_mine (grid cell or drain word)
//   result_out  out   row_index, col_index, cell_mine, neighbor_count, frame_last
//   cfg_*       in    write enable, register index, 11-bit data
//
// one cell word per clock while ready is high; two-stage path: line store read,
// then window update and line store write-back at the following edge.
// a row-end word yields up to two results; with the eight-word result queue
// cell_in.ready drops only while result_out stalls.
// synchronous reset; the line store needs no clearing since row 0 ignores it.
// a register write restarts the frame.

module mine_neighbor_count_3x3 #(
  parameter int MAX_COLS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  mnc_cell_if.sink                  cell_in,
  mnc_result_if.source              result_out,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mnc_pkg::CFG_W-1:0] cfg_data
);
  import mnc_pkg::*;

  localparam int MEM_DEPTH = (MAX_COLS < 2048) ? MAX_COLS : 2048;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int Q_DEPTH   = 8;

  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;
  logic [CFG_W-1:0] row_counter;
  logic [AW-1:0]    col_counter;
  logic [WIN_W-1:0] window;

  logic             s1_valid;
  logic [CFG_W-1:0] s1_row;
  logic [AW-1:0]    s1_col;
  logic             s1_bit;
  logic             s1_last;

  logic             drain_row;
  logic             last_col;
  logic             take;
  logic             go;
  logic [3:0]       q_count;

  logic [1:0]       store_q;
  logic [1:0]       old_rows;
  logic [2:0]       new_col;
  logic [WIN_W-1:0] win_in;
  logic [WIN_W-1:0] win;
  logic [AW-1:0]    prev_col;
  logic [1:0]       push_n;
  result_t          res_a;
  result_t          res_b;
  result_t          push0;
  result_t          push1;
  logic             emit_a;
  logic             emit_b;

  // stage 0: accept, counters, line store read
  assign drain_row     = (row_counter >= grid_rows);
  assign last_col      = (CFG_W'(col_counter) == CFG_W'(grid_cols - 1'b1));
  assign cell_in.ready = (32'(q_count) + (s1_valid ? 32'd2 : 32'd0) + 32'd2 <= Q_DEPTH);
  assign take          = cell_in.valid && cell_in.ready;
  assign go            = take && (cell_in.req_type == drain_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= CFG_W'(1);
      grid_cols <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows <= clamp_size(cfg_data, MAX_ROWS);
        REG_GRID_COLS: grid_cols <= clamp_size(cfg_data, MAX_COLS);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row_counter <= '0;
      col_counter <= '0;
      s1_valid    <= 1'b0;
    end else begin
      s1_valid <= go;
      if (go) begin
        if (last_col) begin
          col_counter <= '0;
          row_counter <= drain_row ? '0 : CFG_W'(row_counter + 1'b1);
        end else begin
          col_counter <= AW'(col_counter + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_row  <= row_counter;
      s1_col  <= col_counter;
      s1_bit  <= cell_in.req_type ? 1'b0 : cell_in.is_mine;
      s1_last <= last_col;
    end
  end

  mnc_line_store #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (go),
    .rd_addr (col_counter),
    .rd_data (store_q),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data ({old_rows[0], s1_bit})
  );

  // stage 1: window shift, write-back, results
  always_comb begin
    old_rows = (s1_row == '0) ? 2'b00 : store_q;
    new_col  = {old_rows, s1_bit};
    win_in   = (s1_col == '0) ? '0 : window;
    win      = {new_col, win_in[WIN_W-1:3]};
    prev_col = AW'(s1_col - 1'b1);
    emit_a   = s1_valid && (s1_row != '0) && (s1_col != '0);
    emit_b   = s1_valid && (s1_row != '0) && s1_last;
    res_a    = make_result(IDX_W'(s1_row - 1'b1), IDX_W'(prev_col), win, 1'b0);
    res_b    = make_result(IDX_W'(s1_row - 1'b1), IDX_W'(s1_col),
                           {3'b000, win[WIN_W-1:3]}, (s1_row == grid_rows));
    push0    = emit_a ? res_a : res_b;
    push1    = res_b;
    push_n   = 2'(emit_a) + 2'(emit_b);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      window <= '0;
    end else if (s1_valid) begin
      window <= s1_last ? '0 : win;
    end
  end

  mnc_result_fifo u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .push0      (push0),
    .push1      (push1),
    .count      (q_count),
    .result_out (result_out)
  );

endmodule
